FILE: rtl/core/rgbscl_pkg.sv
// ----------------------------------------------------------------------------
// rgbscl_pkg: shared types and constants of the RGB32 scaler
// Register indexes, field widths and the size clamp used by the scaler core.
// ----------------------------------------------------------------------------
package rgbscl_pkg;

  localparam int unsigned DIM_W       = 9;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned ACC_W       = 10;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_WIDTH   = 2'd0,
    CFG_IN_HEIGHT  = 2'd1,
    CFG_OUT_WIDTH  = 2'd2,
    CFG_OUT_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PRODUCE = 1'b1
  } op_e;

  // a zero size counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rgbscl_ram.sv
// ----------------------------------------------------------------------------
// rgbscl_ram: single-port RAM with registered read
// One write and one read per cycle; read data is valid the cycle after address.
// ----------------------------------------------------------------------------
module rgbscl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/rgb32_scaler_3x3_smoothing_top.sv
// ----------------------------------------------------------------------------
// rgb32_scaler_3x3_smoothing_top: RGB32 image scaler with 3x3 smoothing
// Frame store, DDA source stepping and a 3x3 smoothing filter per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser selects the word kind. Load words (tuser 0) write
//   tdata pixel_value at pixel_index into the frame store; the block stays ready.
//   Produce words (tuser 1) emit the next output pixel in raster order on the
//   master stream; tlast marks the last pixel of the output frame.
//   A produce word keeps the block busy until its pixel is handed over, also
//   through a row update on the last pixel of an output row. The nine
//   neighbor reads go one per cycle through the single frame store port while a
//   one-bit-per-cycle divider (10 steps) runs the column DDA; at a row end the
//   same divider runs again for the row DDA.
//   Configuration words set the four size registers; the cfg channel is always
//   ready and the user writes it only while the block is idle; no check enforces it.
//   Reset sets all sizes to 1 and the position counters to zero; the frame
//   store holds no defined data until written.
//   When the receiver stalls, the finished pixel holds in the output
//   register; loads keep flowing, and the next produce word waits before
//   handing over its pixel until the register is free.
// ----------------------------------------------------------------------------
module rgb32_scaler_3x3_smoothing_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pixel_index[15:0], pixel_value[47:16]
  input  logic        s_axis_tuser,   // op[0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_pixel[31:0]
  output logic        m_axis_tlast    // frame_last
);

  localparam int unsigned DW  = rgbscl_pkg::DIM_W;
  localparam int unsigned AW  = rgbscl_pkg::ADDR_W;
  localparam int unsigned SW  = rgbscl_pkg::SUM_W;
  localparam int unsigned CW  = rgbscl_pkg::ACC_W;
  localparam int unsigned DimMax = (1 << rgbscl_pkg::DIM_W) - 1;
  localparam logic [DW-1:0] MaxW = DW'((MAX_WIDTH  > DimMax) ? DimMax : MAX_WIDTH);
  localparam logic [DW-1:0] MaxH = DW'((MAX_HEIGHT > DimMax) ? DimMax : MAX_HEIGHT);
  localparam logic [3:0]    LastCyc = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_UPD,
    S_ROWDIV,
    S_ROWUPD,
    S_OUT
  } state_e;

  state_e state_q;
  logic [3:0]    cyc_q;
  logic [1:0]    ri_q, ci_q;
  logic          rd_vld_q, rd_ctr_q;
  logic          last_q;
  logic [DW-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
  logic [DW-1:0] out_col_q, out_row_q, src_col_q, src_row_q;
  logic [DW-1:0] col_accum_q, row_accum_q;

  // datapath
  logic [DW-1:0] rows_q [3];
  logic [DW-1:0] cols_q [3];
  logic [SW-1:0] sum_q  [3];
  logic [7:0]    alpha_q;
  logic [DW-1:0] div_rem_q, div_den_q;
  logic [CW-1:0] div_quo_q;

  logic [DW-1:0] iw, ih, ow, oh;
  logic [DW-1:0] cc, cr, cc_lo, cc_hi, cr_lo, cr_hi;
  logic          s_acc, load_acc, prod_acc, issue;
  logic [CW-1:0] div_t;
  logic          div_ge;
  logic [DW-1:0] div_rem_d;
  logic [CW-1:0] div_quo_d;
  logic [DW-1:0] col_nxt, row_nxt;
  logic          col_wrap, row_wrap;
  logic [17:0]   addr_full;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;

  assign iw = rgbscl_pkg::eff_size(in_width_q,   MaxW);
  assign ih = rgbscl_pkg::eff_size(in_height_q,  MaxH);
  assign ow = rgbscl_pkg::eff_size(out_width_q,  MaxW);
  assign oh = rgbscl_pkg::eff_size(out_height_q, MaxH);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign load_acc = s_acc && (s_axis_tuser == rgbscl_pkg::OP_LOAD);
  assign prod_acc = s_acc && (s_axis_tuser == rgbscl_pkg::OP_PRODUCE);
  assign issue    = (state_q == S_RUN) && (cyc_q < LastCyc);

  // centre saturates to the image, neighbors clamp at the edges
  always_comb begin
    cc    = (src_col_q < iw) ? src_col_q : iw - DW'(1);
    cr    = (src_row_q < ih) ? src_row_q : ih - DW'(1);
    cc_lo = (cc == '0) ? '0 : cc - DW'(1);
    cr_lo = (cr == '0) ? '0 : cr - DW'(1);
    cc_hi = (({1'b0, cc} + CW'(1)) >= {1'b0, iw}) ? iw - DW'(1) : cc + DW'(1);
    cr_hi = (({1'b0, cr} + CW'(1)) >= {1'b0, ih}) ? ih - DW'(1) : cr + DW'(1);
  end

  // restoring divider step
  always_comb begin
    div_t     = {div_rem_q, div_quo_q[CW-1]};
    div_ge    = div_t >= {1'b0, div_den_q};
    div_rem_d = div_ge ? DW'(div_t - {1'b0, div_den_q}) : div_t[DW-1:0];
    div_quo_d = {div_quo_q[CW-2:0], div_ge};
  end

  assign col_nxt  = out_col_q + DW'(1);
  assign row_nxt  = out_row_q + DW'(1);
  assign col_wrap = (col_nxt >= ow) || (col_nxt == '0);
  assign row_wrap = (row_nxt >= oh) || (row_nxt == '0);

  assign addr_full = 18'(rows_q[ri_q]) * 18'(iw) + 18'(cols_q[ci_q]);
  assign ram_we    = load_acc;
  assign ram_addr  = (state_q == S_IDLE) ? s_axis_tdata[15:0] : addr_full[AW-1:0];

  rgbscl_ram #(
    .WIDTH (rgbscl_pkg::PIX_W),
    .DEPTH (rgbscl_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata[47:16]),
    .rdata_o (ram_rdata)
  );

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cyc_q         <= '0;
      ri_q          <= '0;
      ci_q          <= '0;
      rd_vld_q      <= 1'b0;
      rd_ctr_q      <= 1'b0;
      last_q        <= 1'b0;
      in_width_q    <= DW'(1);
      in_height_q   <= DW'(1);
      out_width_q   <= DW'(1);
      out_height_q  <= DW'(1);
      out_col_q     <= '0;
      out_row_q     <= '0;
      src_col_q     <= '0;
      src_row_q     <= '0;
      col_accum_q   <= '0;
      row_accum_q   <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (rgbscl_pkg::cfg_reg_e'(cfg_index_i))
          rgbscl_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg_data_i;
          rgbscl_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg_data_i;
          rgbscl_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
          rgbscl_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data_i;
          default: ;
        endcase
      end

      // drop the word once taken, unless the sequencer reloads it this cycle
      if (m_axis_tvalid && m_axis_tready && (state_q != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      rd_vld_q <= issue;
      rd_ctr_q <= (ri_q == 2'd1) && (ci_q == 2'd1);

      case (state_q)
        S_IDLE: begin
          if (prod_acc) begin
            state_q <= S_RUN;
            cyc_q   <= '0;
            ri_q    <= '0;
            ci_q    <= '0;
          end
        end
        S_RUN: begin
          if (issue) begin
            if (ci_q == 2'd2) begin
              ci_q <= '0;
              ri_q <= ri_q + 2'd1;
            end else begin
              ci_q <= ci_q + 2'd1;
            end
          end
          if (cyc_q == LastCyc) begin
            cyc_q   <= '0;
            state_q <= S_UPD;
          end else begin
            cyc_q <= cyc_q + 4'd1;
          end
        end
        S_UPD: begin
          if (col_wrap) begin
            out_col_q   <= '0;
            src_col_q   <= '0;
            col_accum_q <= '0;
            cyc_q       <= '0;
            state_q     <= S_ROWDIV;
          end else begin
            out_col_q   <= col_nxt;
            src_col_q   <= src_col_q + div_quo_q[DW-1:0];
            col_accum_q <= div_rem_q;
            last_q      <= 1'b0;
            state_q     <= S_OUT;
          end
        end
        S_ROWDIV: begin
          if (cyc_q == LastCyc) begin
            cyc_q   <= '0;
            state_q <= S_ROWUPD;
          end else begin
            cyc_q <= cyc_q + 4'd1;
          end
        end
        S_ROWUPD: begin
          if (row_wrap) begin
            out_row_q   <= '0;
            src_row_q   <= '0;
            row_accum_q <= '0;
            last_q      <= 1'b1;
          end else begin
            out_row_q   <= row_nxt;
            src_row_q   <= src_row_q + div_quo_q[DW-1:0];
            row_accum_q <= div_rem_q;
            last_q      <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {alpha_q, sum_q[2][SW-1:4], sum_q[1][SW-1:4],
                              sum_q[0][SW-1:4]};
            m_axis_tlast  <= last_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (prod_acc) begin
      cols_q[0] <= cc_lo;
      cols_q[1] <= cc;
      cols_q[2] <= cc_hi;
      rows_q[0] <= cr_lo;
      rows_q[1] <= cr;
      rows_q[2] <= cr_hi;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= SW'(8);
      end
      div_rem_q <= '0;
      div_quo_q <= CW'(col_accum_q) + CW'(iw);
      div_den_q <= ow;
    end else if (state_q == S_UPD) begin
      div_rem_q <= '0;
      div_quo_q <= CW'(row_accum_q) + CW'(ih);
      div_den_q <= oh;
    end else if (state_q == S_RUN || state_q == S_ROWDIV) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= div_quo_d;
    end

    if (state_q == S_RUN && rd_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        // centre weighs 8, neighbors 1
        sum_q[k] <= sum_q[k] + (rd_ctr_q ? {1'b0, ram_rdata[8*k +: 8], 3'b000}
                                         : SW'(ram_rdata[8*k +: 8]));
      end
      if (rd_ctr_q) begin
        alpha_q <= ram_rdata[31:24];
      end
    end
  end

  // checks
  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN || state_q == S_ROWDIV) |-> (div_rem_q < div_den_q))
    else $error("divider remainder not below divisor");

  a_cyc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cyc_q <= LastCyc)
    else $error("step counter out of range");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
    else $error("output word not issued by the sequencer");

  a_row_end_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWUPD) |-> (out_col_q == '0 && src_col_q == '0 && col_accum_q == '0))
    else $error("column counters not cleared at row end");

endmodule
